// File: rtl/sac_pkg.sv
// Shared types and constants for the set-associative cache hit/miss tracker.
`default_nettype none
package sac_pkg;
    localparam int unsigned SETS_DEF      = 256;
    localparam int unsigned WAYS_DEF      = 8;
    localparam int unsigned ADDR_BITS_DEF = 48;
    localparam int unsigned CFG_W         = 4;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CNT_W         = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LRU_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WAYS = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // zero one set row per cycle after reset
        logic load;    // capture request, launch set read
        logic commit;  // evaluate set, write back, update counts
    } t_cmd;
endpackage
`default_nettype wire

// File: rtl/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sac_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/sac_ctrl.sv
// Controller: runs the clearing pass after reset, then sequences one request through set read and write-back.
`default_nettype none
module sac_ctrl (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire logic      i_clr_last,
    output logic           busy,
    output sac_pkg::t_cmd  o_cmd
);
    sac_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sac_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.clear  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        busy         = 1'b0;
        case (r_state)
            sac_pkg::ST_CLEAR: begin
                busy        = 1'b1;
                o_cmd.clear = 1'b1;
                if (i_clr_last) begin
                    n_state = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = sac_pkg::ST_LOOK;
                end
            end
            sac_pkg::ST_LOOK: begin
                busy         = 1'b1;
                o_cmd.commit = 1'b1;
                n_state      = sac_pkg::ST_IDLE;
            end
            default: n_state = sac_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/sac_dp.sv
// Datapath: address split, tag/age store, hit and victim logic, counters.
`default_nettype none
module sac_dp #(
    parameter int unsigned SETS      = sac_pkg::SETS_DEF,
    parameter int unsigned WAYS      = sac_pkg::WAYS_DEF,
    parameter int unsigned ADDR_BITS = sac_pkg::ADDR_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sac_pkg::t_cmd                i_cmd,
    input  wire logic                         i_cfg_we,
    input  wire logic [sac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sac_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [ADDR_BITS-1:0]         i_address,
    input  wire logic                         i_is_write,
    output logic                              o_clr_last,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic                              o_mem_read,
    output logic [sac_pkg::CNT_W-1:0]         o_read_total,
    output logic [sac_pkg::CNT_W-1:0]         o_write_total,
    output logic [sac_pkg::CNT_W-1:0]         o_hit_total,
    output logic [sac_pkg::CNT_W-1:0]         o_miss_total
);
    localparam int unsigned SET_W  = SETS > 1 ? $clog2(SETS) : 1;
    localparam int unsigned RANK_W = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int unsigned WCNT_W = $clog2(WAYS + 1);
    localparam int unsigned TAG_W  = ADDR_BITS;
    localparam int unsigned CBASE  = WAYS * (TAG_W + RANK_W);
    localparam int unsigned ROW_W  = CBASE + WCNT_W;
    localparam int unsigned RBASE  = WAYS * TAG_W;
    localparam logic [sac_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam int unsigned WAY_IW = WAYS > 1 ? $clog2(WAYS) : 1;

    // configuration
    logic                      r_lru_mode;
    logic [sac_pkg::CFG_W-1:0] r_offset_bits, r_set_bits, r_active_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lru_mode    <= 1'b0;
            r_offset_bits <= sac_pkg::CFG_W'(6);
            r_set_bits    <= '0;
            r_active_ways <= sac_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sac_pkg::REG_LRU_MODE:    r_lru_mode    <= i_cfg_data[0];
                sac_pkg::REG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                sac_pkg::REG_SET_BITS:    r_set_bits    <= i_cfg_data;
                sac_pkg::REG_ACTIVE_WAYS: r_active_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // address split at request capture
    logic [ADDR_BITS-1:0] set_full, set_mask, tag_in;
    logic [SET_W-1:0]     set_in;
    logic [4:0]           tag_sh;

    always_comb begin
        set_mask = (ADDR_BITS'(1) << r_set_bits) - ADDR_BITS'(1);
        set_full = (i_address >> r_offset_bits) & set_mask;
        set_in   = set_full[SET_W-1:0];
        tag_sh   = 5'(r_offset_bits) + 5'(r_set_bits);
        tag_in   = i_address >> tag_sh;
    end

    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_wr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set <= set_in;
            r_tag <= tag_in;
            r_wr  <= i_is_write;
        end
    end

    // clearing pass after reset: one row per cycle
    logic [SET_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + SET_W'(1);
        end
    end

    assign o_clr_last = (r_clr_addr == SET_W'(SETS - 1));

    // row holds tags, ranks and the set fill count; valid ways form a prefix 0..count-1
    logic [ROW_W-1:0] row_rd, row_wr, ram_wdata;
    logic [SET_W-1:0] ram_waddr;
    logic             ram_we;

    assign ram_we    = i_cmd.commit || i_cmd.clear;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_set;
    assign ram_wdata = i_cmd.clear ? '0 : row_wr;

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (set_in),
        .o_rdata (row_rd)
    );

    // lookup and replacement
    logic [WCNT_W-1:0] cnt, ways, n_cnt;
    logic              hit, fill;
    logic [WAY_IW-1:0] sel;

    always_comb begin
        logic [TAG_W-1:0]  tags  [WAYS];
        logic [RANK_W-1:0] ranks [WAYS];
        logic [WAY_IW-1:0] hway, vict;
        logic [RANK_W-1:0] r_old;
        logic              do_age;
        cnt  = row_rd[CBASE +: WCNT_W];
        ways = (r_active_ways == '0) ? WCNT_W'(1) :
               (32'(r_active_ways) > WAYS) ? WCNT_W'(WAYS) : WCNT_W'(r_active_ways);
        for (int k = 0; k < WAYS; k++) begin
            tags[k]  = row_rd[k*TAG_W +: TAG_W];
            ranks[k] = row_rd[RBASE + k*RANK_W +: RANK_W];
        end
        hit  = 1'b0;
        hway = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (WCNT_W'(k) < cnt && WCNT_W'(k) < ways && tags[k] == r_tag) begin
                hit  = 1'b1;
                hway = WAY_IW'(k);
            end
        end
        vict = '0;
        for (int k = 1; k < WAYS; k++) begin
            if (WCNT_W'(k) < ways && ranks[k] < ranks[vict]) begin
                vict = WAY_IW'(k);
            end
        end
        fill = !hit && (cnt < ways);
        sel  = hit ? hway : (fill ? WAY_IW'(cnt) : vict);
        n_cnt = fill ? cnt + WCNT_W'(1) : cnt;
        do_age = !fill && (!hit || r_lru_mode);
        r_old  = ranks[sel];
        for (int k = 0; k < WAYS; k++) begin
            if (do_age && WCNT_W'(k) < cnt && ranks[k] > r_old) begin
                ranks[k] = ranks[k] - RANK_W'(1);
            end
        end
        if (fill) begin
            ranks[sel] = RANK_W'(cnt);
        end else if (do_age) begin
            ranks[sel] = RANK_W'(cnt - WCNT_W'(1));
        end
        if (!hit) begin
            tags[sel] = r_tag;
        end
        for (int k = 0; k < WAYS; k++) begin
            row_wr[k*TAG_W +: TAG_W]           = tags[k];
            row_wr[RBASE + k*RANK_W +: RANK_W] = ranks[k];
        end
        row_wr[CBASE +: WCNT_W] = n_cnt;
    end

    // counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid       <= 1'b0;
            o_read_total  <= '0;
            o_write_total <= '0;
            o_hit_total   <= '0;
            o_miss_total  <= '0;
        end else begin
            o_valid <= i_cmd.commit;
            if (i_cmd.commit) begin
                if (r_wr && o_write_total != CNT_MAX) begin
                    o_write_total <= o_write_total + sac_pkg::CNT_W'(1);
                end
                if (hit) begin
                    if (o_hit_total != CNT_MAX) o_hit_total <= o_hit_total + sac_pkg::CNT_W'(1);
                end else begin
                    if (o_miss_total != CNT_MAX) o_miss_total <= o_miss_total + sac_pkg::CNT_W'(1);
                    if (o_read_total != CNT_MAX) o_read_total <= o_read_total + sac_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit      <= hit;
            o_mem_read <= !hit;
        end
    end

    a_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.commit))
        else $error("result strobe without a committed request");
    a_hit_xor_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit != o_mem_read))
        else $error("hit and fetch flags disagree");
    a_reads_eq_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_read_total == o_miss_total)
        else $error("fetch count differs from miss count");
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (32'(n_cnt) <= WAYS))
        else $error("set fill count beyond way count");
endmodule
`default_nettype wire

// File: rtl/set_assoc_cache_hit_miss.sv
// Top level: set-associative cache hit/miss tracker with FIFO/LRU replacement.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | i_address, i_is_write                   | start & !busy
//  result   | o_hit, o_mem_read, o_*_total            | o_valid, one cycle
//  config   | i_cfg_idx, i_cfg_data                   | i_cfg_we
//
// A request reads the set row (tags, ages, fill count) from RAM, then looks it up
// and writes it back. The result strobe is registered and follows in the next cycle.
// busy is high in the lookup cycle; a new request may start the cycle after.
// After reset (i_rst_n low, synchronous) a clearing pass zeroes one set row per
// cycle, all SETS rows (256 by default), with busy high. The receiver cannot stall.
`default_nettype none
module set_assoc_cache_hit_miss #(
    parameter int unsigned SETS      = sac_pkg::SETS_DEF,
    parameter int unsigned WAYS      = sac_pkg::WAYS_DEF,
    parameter int unsigned ADDR_BITS = sac_pkg::ADDR_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ADDR_BITS-1:0]          i_address,
    input  wire logic                          i_is_write,
    input  wire logic                          i_cfg_we,
    input  wire logic [sac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sac_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic                               o_mem_read,
    output logic [sac_pkg::CNT_W-1:0]          o_read_total,
    output logic [sac_pkg::CNT_W-1:0]          o_write_total,
    output logic [sac_pkg::CNT_W-1:0]          o_hit_total,
    output logic [sac_pkg::CNT_W-1:0]          o_miss_total
);
    sac_pkg::t_cmd cmd;
    logic          clr_last;

    sac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_clr_last (clr_last),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    sac_dp #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_address     (i_address),
        .i_is_write    (i_is_write),
        .o_clr_last    (clr_last),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_mem_read    (o_mem_read),
        .o_read_total  (o_read_total),
        .o_write_total (o_write_total),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total)
    );
endmodule
`default_nettype wire

// File: dv/set_assoc_cache_hit_miss_checker.sv
// Checker: predicts cache hit/miss results from observed requests and compares them.
`timescale 1ns / 1ps
module set_assoc_cache_hit_miss_checker
    import sac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic [47:0]          i_address,
    input  wire logic                 i_is_write,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    input  wire logic                 i_hit,
    input  wire logic                 i_mem_read,
    input  wire logic [CNT_W-1:0]     i_read_total,
    input  wire logic [CNT_W-1:0]     i_write_total,
    input  wire logic [CNT_W-1:0]     i_hit_total,
    input  wire logic [CNT_W-1:0]     i_miss_total,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);
    localparam int NSETS = SETS_DEF;
    localparam int NWAYS = WAYS_DEF;

    typedef struct packed {
        logic             hit;
        logic             mem_read;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] writes;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } t_access_result;

    t_access_result expected_results[$];

    logic        cfg_lru;
    logic [3:0]  cfg_offset;
    logic [3:0]  cfg_set_bits;
    logic [3:0]  cfg_ways;

    logic        line_valid [NSETS*NWAYS];
    logic [47:0] line_tag   [NSETS*NWAYS];
    int          line_rank  [NSETS*NWAYS];
    logic [CNT_W-1:0] cnt_reads, cnt_writes, cnt_hits, cnt_misses;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    function automatic int filled_ways(input int base);
        int n;
        n = 0;
        for (int k = 0; k < NWAYS; k++) n += line_valid[base+k] ? 1 : 0;
        return n;
    endfunction

    task automatic promote_way(input int base, input int w);
        int r;
        int top;
        r = line_rank[base+w];
        top = filled_ways(base) - 1;
        for (int k = 0; k < NWAYS; k++)
            if (line_valid[base+k] && line_rank[base+k] > r) line_rank[base+k]--;
        line_rank[base+w] = top;
    endtask

    task automatic lookup_access(input logic [47:0] addr, input logic wr);
        longint unsigned a;
        longint unsigned set_idx;
        logic [47:0]     tag;
        int              nways, base, victim;
        bit              found, placed;
        t_access_result  res;
        a = addr;
        found = 0;
        placed = 0;
        nways = (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : cfg_ways);
        set_idx = (a >> cfg_offset) & ((64'd1 << cfg_set_bits) - 1);
        set_idx = set_idx % NSETS;
        tag = 48'(a >> (int'(cfg_offset) + int'(cfg_set_bits)));
        base = int'(set_idx) * NWAYS;
        if (wr) cnt_writes = bump(cnt_writes);
        for (int k = 0; k < nways; k++) begin
            if (!line_valid[base+k]) begin
                line_rank[base+k] = filled_ways(base);
                line_valid[base+k] = 1'b1;
                line_tag[base+k] = tag;
                placed = 1;
                break;
            end
            if (line_tag[base+k] == tag) begin
                found = 1;
                if (cfg_lru) promote_way(base, k);
                break;
            end
        end
        if (!found && !placed) begin
            victim = 0;
            for (int k = 1; k < nways; k++)
                if (line_rank[base+k] < line_rank[base+victim]) victim = k;
            line_tag[base+victim] = tag;
            promote_way(base, victim);
        end
        if (found) begin
            cnt_hits = bump(cnt_hits);
        end else begin
            cnt_misses = bump(cnt_misses);
            cnt_reads = bump(cnt_reads);
        end
        res.hit = found;
        res.mem_read = !found;
        res.reads = cnt_reads;
        res.writes = cnt_writes;
        res.hits = cnt_hits;
        res.misses = cnt_misses;
        expected_results.push_back(res);
    endtask

    task automatic compare_field(input string name, input longint unsigned exp_v,
                                 input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        t_access_result e;
        if (!i_rst_n) begin
            cfg_lru = 1'b0;
            cfg_offset = 4'd6;
            cfg_set_bits = 4'd0;
            cfg_ways = 4'd1;
            for (int i = 0; i < NSETS*NWAYS; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i] = '0;
                line_rank[i] = 0;
            end
            cnt_reads = '0;
            cnt_writes = '0;
            cnt_hits = '0;
            cnt_misses = '0;
            expected_results.delete();
        end else begin
            // result strobe first: its expectation was queued on an earlier edge
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    compare_field("hit", e.hit, i_hit);
                    compare_field("mem_read", e.mem_read, i_mem_read);
                    compare_field("read_total", e.reads, i_read_total);
                    compare_field("write_total", e.writes, i_write_total);
                    compare_field("hit_total", e.hits, i_hit_total);
                    compare_field("miss_total", e.misses, i_miss_total);
                    o_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LRU_MODE:    cfg_lru = i_cfg_data[0];
                    REG_OFFSET_BITS: cfg_offset = i_cfg_data;
                    REG_SET_BITS:    cfg_set_bits = i_cfg_data;
                    REG_ACTIVE_WAYS: cfg_ways = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) lookup_access(i_address, i_is_write);
        end
        o_pending = expected_results.size();
    end
endmodule

// File: dv/set_assoc_cache_hit_miss_tb.sv
// Testbench top: drives accesses and configuration into the cache tracker, reports verdict.
`timescale 1ns / 1ps
module set_assoc_cache_hit_miss_tb;
    import sac_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [47:0]          i_address = '0;
    logic                 i_is_write = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_LRU_MODE;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_valid, o_hit, o_mem_read;
    logic [CNT_W-1:0]     o_read_total, o_write_total, o_hit_total, o_miss_total;
    int                   error_count, pending_count, checked_count;

    int          sent_requests = 0;
    int          cfg_phases = 0;
    logic [47:0] tag_pool [8];
    logic [3:0]  cur_offset = 4'd6;
    logic [3:0]  cur_set_bits = 4'd0;
    logic [3:0]  cur_ways = 4'd1;

    always #5 i_clk = ~i_clk;

    set_assoc_cache_hit_miss u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_address, .i_is_write,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_valid, .o_hit, .o_mem_read,
        .o_read_total, .o_write_total, .o_hit_total, .o_miss_total
    );

    set_assoc_cache_hit_miss_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_address, .i_is_write,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid(o_valid), .i_hit(o_hit),
        .i_mem_read(o_mem_read), .i_read_total(o_read_total),
        .i_write_total(o_write_total), .i_hit_total(o_hit_total),
        .i_miss_total(o_miss_total), .o_errors(error_count),
        .o_pending(pending_count), .o_checked(checked_count)
    );

    // hold start until the request is taken
    task automatic issue(input logic [47:0] addr, input logic wr);
        start <= 1'b1;
        i_address <= addr;
        i_is_write <= wr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_requests++;
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_OFFSET_BITS: cur_offset = val;
            REG_SET_BITS:    cur_set_bits = val;
            REG_ACTIVE_WAYS: cur_ways = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic lru, input logic [3:0] off,
                              input logic [3:0] sb, input logic [3:0] ways);
        drain();
        write_reg(REG_LRU_MODE, {3'b0, lru});
        write_reg(REG_OFFSET_BITS, off);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_ACTIVE_WAYS, ways);
        i_cfg_we <= 1'b0;
        cfg_phases++;
        for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};
    endtask

    // mostly recurring tags in a handful of sets so hits and evictions occur
    function automatic logic [47:0] pick_address();
        longint unsigned a, tag, set_v, low;
        int sh;
        if ($urandom_range(99) < 10) return {$urandom, $urandom};
        sh = cur_offset + cur_set_bits;
        set_v = $urandom_range(3);
        if ($urandom_range(3) == 0) set_v = $urandom;
        set_v &= (64'd1 << cur_set_bits) - 1;
        tag = $urandom_range(cur_ways + 3);
        if ($urandom_range(4) == 0) tag = tag_pool[$urandom_range(7)];
        low = {$urandom, $urandom};
        low &= (64'd1 << cur_offset) - 1;
        a = (tag << sh) | (set_v << cur_offset) | low;
        return a[47:0];
    endfunction

    initial begin
        logic [3:0] offs, sbs, wys;
        bit         quiet;
        for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: direct-mapped, single set
        issue('0, 1'b0);
        issue('0, 1'b1);
        issue('1, 1'b0);
        issue('1, 1'b1);
        issue(48'h0000_0000_003F, 1'b0);
        issue(48'h0000_0000_0040, 1'b1);
        set_config(1'b1, 4'd0, 4'd8, 4'd8);
        issue(48'h0000_0000_0000, 1'b0);
        issue(48'h0000_0000_0100, 1'b0);
        issue(48'h0000_0000_0000, 1'b1);
        issue(48'hAAAA_AAAA_AA00, 1'b0);
        issue(48'h5555_5555_5500, 1'b1);
        set_config(1'b0, 4'd12, 4'd15, 4'd0);  // out-of-range set bits, zero ways
        issue('1, 1'b0);
        issue(48'h0000_0010_0000, 1'b1);
        issue('1, 1'b1);
        set_config(1'b1, 4'd15, 4'd0, 4'd15);  // ways clamp to the maximum
        for (int i = 0; i < 10; i++) issue(48'(i) << 15, i[0]);
        issue(48'h0, 1'b0);

        // random phases over a spread of geometries and both policies
        quiet = 0;
        for (int ph = 0; ph < 14; ph++) begin
            case (ph % 7)
                0: begin offs = 0; sbs = 0; wys = 1; end
                1: begin offs = 12; sbs = 8; wys = 8; end
                2: begin offs = 6; sbs = 2; wys = 4; end
                3: begin offs = 3; sbs = 1; wys = 3; end
                4: begin offs = 4; sbs = 9; wys = 2; end
                5: begin offs = 15; sbs = 15; wys = 15; end
                default: begin
                    offs = $urandom_range(15);
                    sbs = $urandom_range(15);
                    wys = $urandom_range(15);
                end
            endcase
            set_config(ph[0], offs, sbs, wys);
            for (int n = 0; n < 50; n++) begin
                quiet = (ph == 4 || ph == 5);
                issue(pick_address(), $urandom_range(1));
                if (!quiet && $urandom_range(99) < 12) pause($urandom_range(1, 4));
                if (n == 25 && ph == 8) drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d accesses over %0d cache geometries, %0d results checked.",
                 sent_requests, cfg_phases, checked_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: sim.f
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_ctrl.sv
rtl/sac_dp.sv
rtl/set_assoc_cache_hit_miss.sv
dv/set_assoc_cache_hit_miss_checker.sv
dv/set_assoc_cache_hit_miss_tb.sv
